// ===== rtl/indexed_sequence_store_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the indexed sequence store
// Clocked property checks that simulation sees and synthesis drops.
// ---------------------------------------------------------------------------
`ifndef INDEXED_SEQUENCE_STORE_MACROS_SVH
`define INDEXED_SEQUENCE_STORE_MACROS_SVH

`ifndef SYNTHESIS
// Property checked on every rising edge, off while reset is asserted
`define ISS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Property checked on every rising edge, reset included
`define ISS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ISS_ASSERT(lbl, clk, rst_n, prop, msg)
`define ISS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== rtl/iss_pkg.sv =====
// ---------------------------------------------------------------------------
// Indexed sequence store package
// Field widths, default sizes, operation and status codes, cell actions.
// ---------------------------------------------------------------------------
package iss_pkg;

    // default sizes
    localparam int CAPACITY_DEF   = 16;
    localparam int DATA_WIDTH_DEF = 32;

    // request and result field widths
    localparam int OP_W  = 3;
    localparam int VAL_W = 32;
    localparam int POS_W = 5;
    localparam int ST_W  = 2;
    localparam int CNT_W = 5;

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_APPEND     = 3'd0,
        OP_PREPEND    = 3'd1,
        OP_TAKE_BACK  = 3'd2,
        OP_TAKE_FRONT = 3'd3,
        OP_INSERT_AT  = 3'd4,
        OP_REMOVE_AT  = 3'd5
    } t_op;

    // status codes
    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    // what one storage cell does on the next edge
    typedef enum logic [1:0] {
        ACT_HOLD  = 2'd0,
        ACT_LOAD  = 2'd1,
        ACT_LEFT  = 2'd2,
        ACT_RIGHT = 2'd3
    } t_cell_act;

endpackage

// ===== rtl/iss_cell.sv =====
// ---------------------------------------------------------------------------
// Indexed sequence store cell
// One slot of the sequence: holds, loads a new value, or takes the value of
// its left or right neighbor to open or close a gap.
// ---------------------------------------------------------------------------
module iss_cell #(
    parameter int DATA_WIDTH = iss_pkg::DATA_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  iss_pkg::t_cell_act    i_act,
    input  logic [DATA_WIDTH-1:0] i_load,
    input  logic [DATA_WIDTH-1:0] i_left,
    input  logic [DATA_WIDTH-1:0] i_right,
    output logic [DATA_WIDTH-1:0] o_data
);
    import iss_pkg::*;

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;

    // next slot value
    always_comb begin
        unique case (i_act)
            ACT_HOLD:  n_data = r_data;
            ACT_LOAD:  n_data = i_load;
            ACT_LEFT:  n_data = i_left;
            ACT_RIGHT: n_data = i_right;
            default:   n_data = r_data;
        endcase
    end

    // slot storage, payload only
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

// ===== rtl/indexed_sequence_store.sv =====
// The result registers load a result when its request is accepted.
// Throughput: one request per cycle while the output is empty or being taken; every
// operation, including insert and remove at any position, finishes in one shift of the cell row.
// A new request is taken while the output register is empty or being taken.
// Reset (synchronous, active low) empties the store and drops the result;
// cell contents are left as they are.
// ---------------------------------------------------------------------------
// Indexed sequence store
// Bounded double-ended queue with insert and remove at any position, built
// as a row of cells that shift toward the back or the front.
// ---------------------------------------------------------------------------
`include "indexed_sequence_store_macros.svh"

module indexed_sequence_store #(
    parameter int CAPACITY   = iss_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = iss_pkg::DATA_WIDTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [iss_pkg::OP_W-1:0]  i_op,
    input  logic [iss_pkg::VAL_W-1:0] i_value,
    input  logic [iss_pkg::POS_W-1:0] i_position,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [iss_pkg::VAL_W-1:0] o_read_value,
    output logic [iss_pkg::ST_W-1:0]  o_status,
    output logic [iss_pkg::CNT_W-1:0] o_count
);
    import iss_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);
    localparam int XW = CW + POS_W;

    // control state
    logic [CW-1:0]         r_occ;
    logic [CW-1:0]         n_occ;
    logic                  r_out_valid;

    // result registers
    logic [VAL_W-1:0]      r_read_value;
    t_status               r_status;
    logic [CNT_W-1:0]      r_count;

    logic                  w_accept;
    logic [XW-1:0]         w_pos_x;
    logic [XW-1:0]         w_occ_x;
    logic                  w_full;
    logic                  w_empty;
    logic                  w_ins;
    logic                  w_rem;
    logic [XW-1:0]         w_target;
    t_status               w_status;
    logic [DATA_WIDTH-1:0] w_rd_data;
    logic [DATA_WIDTH+VAL_W-1:0] w_rd_ext;
    logic [DATA_WIDTH+VAL_W-1:0] w_val_ext;
    logic [DATA_WIDTH-1:0] w_load;
    logic [CW+CNT_W-1:0]   w_cnt_ext;

    logic [DATA_WIDTH-1:0] w_cell [CAPACITY];
    t_cell_act             w_act  [CAPACITY];

    // handshake
    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;

    // widened operands for position checks
    assign w_pos_x = {{CW{1'b0}}, i_position};
    assign w_occ_x = {{POS_W{1'b0}}, r_occ};
    assign w_full  = (w_occ_x >= XW'(CAPACITY));
    assign w_empty = (r_occ == '0);

    // operation decode: status, shift direction, target slot, new count
    always_comb begin
        w_ins    = 1'b0;
        w_rem    = 1'b0;
        w_target = '0;
        w_status = ST_OK;
        n_occ    = r_occ;
        unique case (i_op)
            OP_APPEND: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_ins    = 1'b1;
                    w_target = w_occ_x;
                end
            end
            OP_PREPEND: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_ins = 1'b1;
                end
            end
            OP_TAKE_BACK: begin
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else begin
                    w_rem    = 1'b1;
                    w_target = w_occ_x - XW'(1);
                end
            end
            OP_TAKE_FRONT: begin
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else begin
                    w_rem = 1'b1;
                end
            end
            OP_INSERT_AT: begin
                if (w_pos_x > w_occ_x) begin
                    w_status = ST_RANGE;
                end else if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_ins    = 1'b1;
                    w_target = w_pos_x;
                end
            end
            OP_REMOVE_AT: begin
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else if (w_pos_x >= w_occ_x) begin
                    w_status = ST_RANGE;
                end else begin
                    w_rem    = 1'b1;
                    w_target = w_pos_x;
                end
            end
            default: begin
                w_status = ST_OK;
            end
        endcase
        if (w_ins) begin
            n_occ = r_occ + CW'(1);
        end else if (w_rem) begin
            n_occ = r_occ - CW'(1);
        end
    end

    // value taken out, and value fitted to the slot width
    assign w_rd_data = w_rem ? w_cell[w_target[IW-1:0]] : '0;
    assign w_rd_ext  = {{VAL_W{1'b0}}, w_rd_data};
    assign w_val_ext = {{DATA_WIDTH{1'b0}}, i_value};
    assign w_load    = w_val_ext[DATA_WIDTH-1:0];
    assign w_cnt_ext = {{CNT_W{1'b0}}, n_occ};

    // row of cells: slots before the target hold; on insert the target loads and the
    // slots behind it shift back; on remove the target and those behind shift forward
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [DATA_WIDTH-1:0] w_left;
        logic [DATA_WIDTH-1:0] w_right;

        always_comb begin
            w_act[g] = ACT_HOLD;
            if (w_accept && w_ins) begin
                if (XW'(g) == w_target) begin
                    w_act[g] = ACT_LOAD;
                end else if (XW'(g) > w_target) begin
                    w_act[g] = ACT_LEFT;
                end
            end else if (w_accept && w_rem) begin
                if (XW'(g) >= w_target) begin
                    w_act[g] = ACT_RIGHT;
                end
            end
        end

        if (g == 0) begin : g_first
            assign w_left = w_cell[g];
        end else begin : g_inner_l
            assign w_left = w_cell[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_right = w_cell[g];
        end else begin : g_inner_r
            assign w_right = w_cell[g+1];
        end

        iss_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .i_clk   (i_clk),
            .i_act   (w_act[g]),
            .i_load  (w_load),
            .i_left  (w_left),
            .i_right (w_right),
            .o_data  (w_cell[g])
        );
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_occ       <= n_occ;
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // result registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_read_value <= w_rd_ext[VAL_W-1:0];
            r_status     <= w_status;
            r_count      <= w_cnt_ext[CNT_W-1:0];
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_read_value = r_read_value;
    assign o_status     = r_status;
    assign o_count      = r_count;

    // checks
    `ISS_ASSERT(a_occ_bound, i_clk, i_rst_n, r_occ <= CW'(CAPACITY), "occupancy above capacity")
    `ISS_ASSERT(a_occ_step, i_clk, i_rst_n, w_accept |=> (r_occ == $past(r_occ)) || (r_occ == $past(r_occ) + CW'(1)) || (r_occ == $past(r_occ) - CW'(1)), "occupancy moved by more than one")
    `ISS_ASSERT(a_refused_zero, i_clk, i_rst_n, (r_out_valid && (r_status != ST_OK)) |-> (r_read_value == '0), "refused request returned a value")
    `ISS_ASSERT(a_empty_count, i_clk, i_rst_n, (w_accept && (w_status == ST_EMPTY)) |=> (r_occ == '0), "empty status with stored values")
    `ISS_ASSERT_ALWAYS(a_no_shift_idle, i_clk, !w_accept |-> (w_act[0] == ACT_HOLD), "cell row moved without a request")

endmodule
